>>> src/pidc_pkg.sv
// shared constants for the clamped pid controller
package pidc_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int GAIN_W           = 24;
    localparam int CLAMP_W          = 16;
    localparam int TIME_W           = 32;
    localparam int INT_W            = 40;
    localparam int DEN_W            = TIME_W + 4;
    localparam int CFG_IDX_W        = 3;

    localparam logic [GAIN_W-1:0]  GAIN_P_RST  = 24'd98304;
    localparam logic [GAIN_W-1:0]  GAIN_I_RST  = 24'd3277;
    localparam logic [GAIN_W-1:0]  GAIN_D_RST  = 24'd6554;
    localparam logic [CLAMP_W-1:0] OUT_MIN_RST = 16'd0;
    localparam logic [CLAMP_W-1:0] OUT_MAX_RST = 16'd65470;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX = 3'd4;

endpackage

>>> src/pid_controller_clamped_top.sv
// pid controller top: sequencer, state, output clamp
// One sample is taken at a time; the sequencer uses one shared shift-add multiplier,
// which forms the proportional product, the integral product and its scaling by
// elapsed time, and the derivative product in turn, followed by a bit-serial
// restoring divide for the derivative; the divide is skipped when the elapsed time
// is zero. A new sample may be accepted while the previous result waits on the
// output.
module pid_controller_clamped_top #(
    parameter int SAMPLE_WIDTH = pidc_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // setpoint, measurement, timestamp_ms, zero pad
    input  logic [((2*SAMPLE_WIDTH+32+7)/8)*8-1:0] s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // drive
    output logic [15:0]                        m_tdata,
    // zero_interval, integral_saturated
    output logic [1:0]                         m_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pidc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pidc_pkg::GAIN_W-1:0]        cfg_data
);
    import pidc_pkg::*;

    localparam int SW  = SAMPLE_WIDTH;
    localparam int EW  = SW + 1;
    localparam int DFW = SW + 2;
    localparam int PMW = GAIN_W + EW;
    localparam int AW  = GAIN_W + EW;
    localparam int BW  = (SW + 2 > TIME_W) ? SW + 2 : TIME_W;
    localparam int NW  = GAIN_W + DFW;
    localparam int PW  = AW + BW;
    localparam int INCW = 59;
    localparam int IW  = INCW + 2;
    localparam int TW  = ((SW + 27 > INT_W) ? SW + 27 : INT_W) + 2;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DIF  = 4'd1;
    localparam logic [3:0] ST_MP   = 4'd2;
    localparam logic [3:0] ST_MI   = 4'd3;
    localparam logic [3:0] ST_MT   = 4'd4;
    localparam logic [3:0] ST_MD   = 4'd5;
    localparam logic [3:0] ST_DV   = 4'd6;
    localparam logic [3:0] ST_IS   = 4'd7;
    localparam logic [3:0] ST_SUM  = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;

    logic [3:0] state_reg, state_next;

    logic [GAIN_W-1:0]  gain_p_reg, gain_i_reg, gain_d_reg;
    logic [CLAMP_W-1:0] out_min_reg, out_max_reg;

    logic signed [INT_W-1:0] integ_reg;
    logic signed [EW-1:0]    prev_err_reg;
    logic [TIME_W-1:0]       prev_time_reg;

    logic signed [EW-1:0]  err_reg;
    logic [TIME_W-1:0]     dt_reg;
    logic [EW-1:0]         emag_reg;
    logic                  eneg_reg;
    logic [DFW-1:0]        dmag_reg;
    logic                  dneg_reg;
    logic signed [PMW:0]   p_term_reg;
    logic [INCW-1:0]       inc_reg;
    logic                  big_reg;
    logic signed [NW:0]    d_term_reg;
    logic signed [INT_W-1:0] isum_reg;
    logic                  isat_reg;
    logic signed [TW-1:0]  total_reg;

    logic                  out_valid_reg;
    logic [15:0]           out_drive_reg;
    logic [1:0]            out_flags_reg;

    logic                  accept;
    logic                  mul_start, mul_done;
    logic [AW-1:0]         mul_a;
    logic [BW-1:0]         mul_b;
    logic [PW-1:0]         mul_prod;
    logic                  div_start, div_done;
    logic [NW-1:0]         div_quot;

    logic signed [EW-1:0]  sp_x, ms_x, err_in;
    logic signed [DFW-1:0] diff;
    logic [PMW:0]          p_full;
    logic [NW:0]           d_full;
    logic signed [IW-1:0]  isum_wide;
    logic [IW-1:0]         inc_s;
    logic                  pd_over;
    logic signed [TW-1:0]  clamp_hi, clamp_lo, after_max;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    assign sp_x   = EW'($signed(s_tdata[SW-1:0]));
    assign ms_x   = EW'($signed(s_tdata[2*SW-1:SW]));
    assign err_in = sp_x - ms_x;
    assign diff   = DFW'(err_reg) - DFW'(prev_err_reg);

    // product of integral term and elapsed time above 2^62 saturates
    assign pd_over = (mul_prod[PW-1:62] != '0)
        && !((mul_prod[PW-1:62] == (PW-62)'(1)) && (mul_prod[61:0] == '0));

    always_comb
    begin
        state_next = state_reg;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        mul_a      = AW'(gain_p_reg);
        mul_b      = BW'(emag_reg);
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DIF;
                end
            end
            ST_DIF:
            begin
                state_next = ST_MP;
                mul_start  = 1'b1;
            end
            ST_MP:
            begin
                if (mul_done)
                begin
                    state_next = ST_MI;
                    mul_start  = 1'b1;
                    mul_a      = AW'(gain_i_reg);
                end
            end
            ST_MI:
            begin
                if (mul_done)
                begin
                    state_next = ST_MT;
                    mul_start  = 1'b1;
                    mul_a      = mul_prod[AW-1:0];
                    mul_b      = BW'(dt_reg);
                end
            end
            ST_MT:
            begin
                if (mul_done)
                begin
                    state_next = ST_MD;
                    mul_start  = 1'b1;
                    mul_a      = AW'(gain_d_reg);
                    mul_b      = BW'(dmag_reg);
                end
            end
            ST_MD:
            begin
                if (mul_done)
                begin
                    if (dt_reg == '0)
                    begin
                        state_next = ST_IS;
                    end
                    else
                    begin
                        state_next = ST_DV;
                        div_start  = 1'b1;
                    end
                end
            end
            ST_DV:
            begin
                if (div_done)
                begin
                    state_next = ST_IS;
                end
            end
            ST_IS:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        p_full    = eneg_reg ? -{1'b0, mul_prod[PMW-1:0]} : {1'b0, mul_prod[PMW-1:0]};
        d_full    = dneg_reg ? -{1'b0, div_quot} : {1'b0, div_quot};
        inc_s     = IW'(inc_reg);
        isum_wide = IW'(integ_reg) + (eneg_reg ? -$signed(inc_s) : $signed(inc_s));
        clamp_hi  = $signed(TW'(out_max_reg));
        clamp_lo  = $signed(TW'(out_min_reg));
        after_max = (total_reg > clamp_hi) ? clamp_hi : total_reg;
    end

    pidc_mul #(
        .AW (AW),
        .BW (BW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    pidc_div #(
        .NW (NW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mul_prod[NW-1:0]),
        .den   ({dt_reg, 4'b0000}),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gain_p_reg    <= GAIN_P_RST;
            gain_i_reg    <= GAIN_I_RST;
            gain_d_reg    <= GAIN_D_RST;
            out_min_reg   <= OUT_MIN_RST;
            out_max_reg   <= OUT_MAX_RST;
            integ_reg     <= '0;
            prev_err_reg  <= '0;
            prev_time_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_GAIN_P:  gain_p_reg  <= cfg_data;
                    CFG_GAIN_I:  gain_i_reg  <= cfg_data;
                    CFG_GAIN_D:  gain_d_reg  <= cfg_data;
                    CFG_OUT_MIN: out_min_reg <= cfg_data[CLAMP_W-1:0];
                    CFG_OUT_MAX: out_max_reg <= cfg_data[CLAMP_W-1:0];
                    default:     ;
                endcase
            end
            if (accept)
            begin
                prev_time_reg <= s_tdata[2*SW+TIME_W-1:2*SW];
            end
            if (state_reg == ST_DIF)
            begin
                prev_err_reg <= err_reg;
            end
            if (state_reg == ST_SUM)
            begin
                integ_reg <= isum_reg;
            end
            if ((state_reg == ST_OUT) && (!out_valid_reg || m_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tvalid && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            err_reg  <= err_in;
            dt_reg   <= s_tdata[2*SW+TIME_W-1:2*SW] - prev_time_reg;
            eneg_reg <= err_in[EW-1];
            emag_reg <= err_in[EW-1] ? EW'(-err_in) : EW'(err_in);
        end
        if (state_reg == ST_DIF)
        begin
            dneg_reg <= diff[DFW-1];
            dmag_reg <= diff[DFW-1] ? DFW'(-diff) : DFW'(diff);
        end
        if ((state_reg == ST_MP) && mul_done)
        begin
            p_term_reg <= $signed(p_full) >>> 4;
        end
        if ((state_reg == ST_MT) && mul_done)
        begin
            big_reg <= pd_over;
            inc_reg <= mul_prod[62:4];
        end
        if ((state_reg == ST_MD) && mul_done)
        begin
            d_term_reg <= '0;
        end
        if ((state_reg == ST_DV) && div_done)
        begin
            d_term_reg <= $signed(d_full);
        end
        if (state_reg == ST_IS)
        begin
            if (big_reg)
            begin
                isat_reg <= 1'b1;
                isum_reg <= eneg_reg ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
            end
            else if (isum_wide > $signed(IW'({1'b0, {(INT_W-1){1'b1}}})))
            begin
                isat_reg <= 1'b1;
                isum_reg <= {1'b0, {(INT_W-1){1'b1}}};
            end
            else if (isum_wide < -$signed(IW'({1'b1, {(INT_W-1){1'b0}}})))
            begin
                isat_reg <= 1'b1;
                isum_reg <= {1'b1, {(INT_W-1){1'b0}}};
            end
            else
            begin
                isat_reg <= 1'b0;
                isum_reg <= isum_wide[INT_W-1:0];
            end
        end
        if (state_reg == ST_SUM)
        begin
            total_reg <= TW'(p_term_reg) + TW'(isum_reg) + TW'(d_term_reg);
        end
        if ((state_reg == ST_OUT) && (!out_valid_reg || m_tready))
        begin
            out_drive_reg <= (after_max < clamp_lo) ? out_min_reg : after_max[15:0];
            out_flags_reg <= {isat_reg, (dt_reg == '0)};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_drive_reg;
    assign m_tuser  = out_flags_reg;

    a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_MP || state_reg == ST_MI
                      || state_reg == ST_MT || state_reg == ST_MD))
        else $error("multiplier finished outside a multiply step");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DV))
        else $error("divider finished outside the divide step");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_DIF))
        else $error("accepted sample did not start the sequence");

    a_no_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (dt_reg != '0))
        else $error("divide started with zero interval");

endmodule

>>> src/pidc_mul.sv
// shift-add serial multiplier, one multiplier bit per cycle
module pidc_mul #(
    parameter int AW = 57,
    parameter int BW = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic             done,
    output logic [AW+BW-1:0] prod
);
    localparam int CW = $clog2(BW + 1);

    logic [AW-1:0]    a_reg;
    logic [AW+BW-1:0] acc_reg, acc_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [AW:0]      sum;

    always_comb
    begin
        sum       = {1'b0, acc_reg[AW+BW-1:BW]} + (acc_reg[0] ? {1'b0, a_reg} : {(AW+1){1'b0}});
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next = {{AW{1'b0}}, b};
            cnt_next = CW'(BW);
        end
        else if (cnt_reg != '0)
        begin
            acc_next  = {sum, acc_reg[BW-1:1]};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (start)
        begin
            a_reg <= a;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

>>> src/pidc_div.sv
// restoring divider, one quotient bit per cycle
module pidc_div #(
    parameter int NW = 42
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [NW-1:0]            num,
    input  logic [pidc_pkg::DEN_W-1:0] den,
    output logic                     done,
    output logic [NW-1:0]            quot
);
    import pidc_pkg::*;

    localparam int CW = $clog2(NW + 1);

    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NW-1:0]    q_reg, q_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb
    begin
        trial     = {rem_reg, q_reg[NW-1]};
        diff      = trial - {1'b0, den_reg};
        ge        = (trial >= {1'b0, den_reg});
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            q_next   = num;
            cnt_next = CW'(NW);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            q_next    = {q_reg[NW-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule
